[hdl/sbsh_pkg.sv]
`timescale 1ns / 1ps
// ============================================================================
// sbsh_pkg
// Shared types, round constants, initial hash values and mixing functions
// for the byte stream hasher.
// ============================================================================
package sbsh_pkg;

    typedef logic [31:0] word_t;
    typedef word_t [0:7] vars_t;

    localparam int unsigned ROUNDS     = 64;
    localparam int unsigned BLOCK_BYTES = 64;
    localparam int unsigned LEN_POS    = 56;

    localparam logic [7:0] PAD_MARKER = 8'h80;

    localparam vars_t HASH_INIT = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam word_t ROUND_K [0:ROUNDS-1] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PAD   = 3'd1;
    localparam logic [2:0] S_LOAD  = 3'd2;
    localparam logic [2:0] S_ROUND = 3'd3;
    localparam logic [2:0] S_FOLD  = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    function automatic word_t rotr(input word_t x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic word_t big_sigma0(input word_t x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic word_t big_sigma1(input word_t x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic word_t small_sigma0(input word_t x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic word_t small_sigma1(input word_t x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

endpackage

[hdl/sbsh_round_unit.sv]
`timescale 1ns / 1ps
// ============================================================================
// sbsh_round_unit
// One compression round: mixes the working variables with one schedule word
// and one round constant.
// ============================================================================
module sbsh_round_unit import sbsh_pkg::*; (
    input  vars_t vars_in,
    input  word_t sched_word,
    input  word_t round_const,
    output vars_t vars_out
);

    word_t ch;
    word_t maj;
    word_t t1;
    word_t t2;

    always_comb begin
        ch  = (vars_in[4] & vars_in[5]) ^ (~vars_in[4] & vars_in[6]);
        maj = (vars_in[0] & vars_in[1]) ^ (vars_in[0] & vars_in[2])
            ^ (vars_in[1] & vars_in[2]);
        t1  = vars_in[7] + big_sigma1(vars_in[4]) + ch + round_const + sched_word;
        t2  = big_sigma0(vars_in[0]) + maj;

        vars_out[0] = t1 + t2;
        vars_out[1] = vars_in[0];
        vars_out[2] = vars_in[1];
        vars_out[3] = vars_in[2];
        vars_out[4] = vars_in[3] + t1;
        vars_out[5] = vars_in[4];
        vars_out[6] = vars_in[5];
        vars_out[7] = vars_in[6];
    end

endmodule

[hdl/sbsh_sched_window.sv]
`timescale 1ns / 1ps
// ============================================================================
// sbsh_sched_window
// Sixteen word window: gathers message bytes big-endian, then rolls as the
// message schedule during a compression.
// ============================================================================
module sbsh_sched_window import sbsh_pkg::*; (
    input  logic       aclk,
    input  logic       byte_shift,
    input  logic [7:0] byte_in,
    input  logic       sched_shift,
    output word_t      cur_word
);

    logic [511:0] win_reg;
    logic [511:0] win_next;
    word_t        w_new;

    assign cur_word = win_reg[511:480];

    always_comb begin
        w_new = small_sigma1(win_reg[63:32]) + win_reg[223:192]
              + small_sigma0(win_reg[479:448]) + win_reg[511:480];
        priority if (byte_shift) begin
            win_next = {win_reg[503:0], byte_in};
        end else if (sched_shift) begin
            win_next = {win_reg[479:0], w_new};
        end else begin
            win_next = win_reg;
        end
    end

    always_ff @(posedge aclk) begin
        win_reg <= win_next;
    end

endmodule

[hdl/sha256_byte_stream_hasher_unit.sv]
`timescale 1ns / 1ps
// ============================================================================
// sha256_byte_stream_hasher_unit
// Byte stream message hasher: one byte per beat, one round per cycle,
// eight digest word beats per message.
// ============================================================================
// a beat that is neither last nor block-filling keeps ready high; a beat that
//   fills a block holds ready low through load, 64 rounds on the shared round
//   unit and fold; a last beat pads one byte per cycle up to the block end,
//   runs one or two compressions, then offers 8 digest beats
// synchronous active-low reset restores the initial hash and empty length
// ============================================================================
module sha256_byte_stream_hasher_unit import sbsh_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_byte_valid,
    input  logic        s_last,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_digest_word,
    output logic [2:0]  m_word_index,
    output logic        m_last_word
);

    logic [2:0]  state_reg,       state_next;
    logic [5:0]  fill_reg,        fill_next;
    logic [63:0] bit_count_reg,   bit_count_next;
    vars_t       hash_reg,        hash_next;
    vars_t       var_reg,         var_next;
    logic [5:0]  round_reg,       round_next;
    logic        pad_active_reg,  pad_active_next;
    logic        marker_done_reg, marker_done_next;
    logic        len_ok_reg,      len_ok_next;
    logic        final_reg,       final_next;
    logic [2:0]  out_idx_reg,     out_idx_next;

    logic        byte_shift;
    logic [7:0]  byte_in;
    logic        sched_shift;
    word_t       cur_word;
    vars_t       round_out;
    logic        in_beat;
    logic        len_phase;

    sbsh_sched_window u_window (
        .aclk        (aclk),
        .byte_shift  (byte_shift),
        .byte_in     (byte_in),
        .sched_shift (sched_shift),
        .cur_word    (cur_word)
    );

    sbsh_round_unit u_round (
        .vars_in     (var_reg),
        .sched_word  (cur_word),
        .round_const (ROUND_K[round_reg]),
        .vars_out    (round_out)
    );

    assign s_ready       = (state_reg == S_IDLE);
    assign in_beat       = s_valid && s_ready;
    assign m_valid       = (state_reg == S_OUT);
    assign m_digest_word = hash_reg[out_idx_reg];
    assign m_word_index  = out_idx_reg;
    assign m_last_word   = (out_idx_reg == 3'd7);

    // length bytes go into the last eight slots of the final block
    assign len_phase = marker_done_reg && len_ok_reg
                    && (fill_reg >= 6'(LEN_POS));

    always_comb begin
        state_next       = state_reg;
        fill_next        = fill_reg;
        bit_count_next   = bit_count_reg;
        hash_next        = hash_reg;
        var_next         = var_reg;
        round_next       = round_reg;
        pad_active_next  = pad_active_reg;
        marker_done_next = marker_done_reg;
        len_ok_next      = len_ok_reg;
        final_next       = final_reg;
        out_idx_next     = out_idx_reg;
        byte_shift       = 1'b0;
        byte_in          = s_data_byte;
        sched_shift      = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                if (in_beat) begin
                    pad_active_next  = s_last;
                    marker_done_next = 1'b0;
                    len_ok_next      = 1'b0;
                    final_next       = 1'b0;
                    if (s_byte_valid) begin
                        byte_shift     = 1'b1;
                        fill_next      = fill_reg + 6'd1;
                        bit_count_next = bit_count_reg + 64'd8;
                    end
                    if (s_byte_valid && fill_reg == 6'(BLOCK_BYTES - 1)) begin
                        state_next = S_LOAD;
                    end else if (s_last) begin
                        state_next = S_PAD;
                    end
                end
            end
            S_PAD: begin
                byte_shift = 1'b1;
                fill_next  = fill_reg + 6'd1;
                priority if (!marker_done_reg) begin
                    byte_in          = PAD_MARKER;
                    marker_done_next = 1'b1;
                    len_ok_next      = (fill_reg < 6'(LEN_POS));
                end else if (len_phase) begin
                    byte_in        = bit_count_reg[63:56];
                    bit_count_next = {bit_count_reg[55:0], 8'd0};
                end else begin
                    byte_in = 8'd0;
                end
                if (fill_reg == 6'(BLOCK_BYTES - 1)) begin
                    final_next = marker_done_reg && len_ok_reg;
                    state_next = S_LOAD;
                end
            end
            S_LOAD: begin
                var_next   = hash_reg;
                round_next = 6'd0;
                state_next = S_ROUND;
            end
            S_ROUND: begin
                var_next    = round_out;
                sched_shift = 1'b1;
                round_next  = round_reg + 6'd1;
                if (round_reg == 6'(ROUNDS - 1)) begin
                    state_next = S_FOLD;
                end
            end
            S_FOLD: begin
                for (int i = 0; i < 8; i++) begin
                    hash_next[i] = hash_reg[i] + var_reg[i];
                end
                priority if (final_reg) begin
                    out_idx_next = 3'd0;
                    state_next   = S_OUT;
                end else if (pad_active_reg) begin
                    len_ok_next = 1'b1;
                    state_next  = S_PAD;
                end else begin
                    state_next = S_IDLE;
                end
            end
            S_OUT: begin
                if (m_ready) begin
                    out_idx_next = out_idx_reg + 3'd1;
                    if (out_idx_reg == 3'd7) begin
                        hash_next       = HASH_INIT;
                        bit_count_next  = 64'd0;
                        fill_next       = 6'd0;
                        pad_active_next = 1'b0;
                        final_next      = 1'b0;
                        state_next      = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            fill_reg        <= 6'd0;
            bit_count_reg   <= 64'd0;
            hash_reg        <= HASH_INIT;
            round_reg       <= 6'd0;
            pad_active_reg  <= 1'b0;
            marker_done_reg <= 1'b0;
            len_ok_reg      <= 1'b0;
            final_reg       <= 1'b0;
            out_idx_reg     <= 3'd0;
        end else begin
            state_reg       <= state_next;
            fill_reg        <= fill_next;
            bit_count_reg   <= bit_count_next;
            hash_reg        <= hash_next;
            round_reg       <= round_next;
            pad_active_reg  <= pad_active_next;
            marker_done_reg <= marker_done_next;
            len_ok_reg      <= len_ok_next;
            final_reg       <= final_next;
            out_idx_reg     <= out_idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        var_reg <= var_next;
    end

endmodule
